// ===== rtl/btmx_pkg.sv =====
// btmx_pkg: shared types and codes for the binary trie max-xor block
// used by btmx_ctrl, btmx_dp and binary_trie_max_xor; no dependencies
`timescale 1ns / 1ps

package btmx_pkg;

    // input commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // input item
    typedef struct packed {
        logic        command;
        logic [31:0] value;
    } t_in;

    // result item
    typedef struct packed {
        logic [31:0] max_xor;
        t_status     status;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // input transfer: latch item, read root
        logic step;      // walk one trie level
        logic load_out;  // capture result into output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic special;   // item at input is answered without a walk
        logic last;      // current level is bit zero
    } t_dp_stat;

endpackage

// ===== rtl/btmx_ctrl.sv =====
// btmx_ctrl: sequencing state machine and output valid for the trie block
// depends on btmx_pkg for the command and status structs
`timescale 1ns / 1ps

module btmx_ctrl import btmx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    // handshake decode
    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // commands to datapath
    always_comb begin
        o_cmd.start    = accept;
        o_cmd.step     = (r_state == S_WALK) && (!i_stat.last || out_free);
        o_cmd.load_out = ((r_state == S_WALK) && i_stat.last && out_free)
                      || ((r_state == S_DONE) && out_free);
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= i_stat.special ? S_DONE : S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_stat.last && out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // a walking item enters the walk state
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_stat.special) |=> (r_state == S_WALK))
        else $error("walk not started after input transfer");

    // a new result only appears after work on an item
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) != S_IDLE))
        else $error("result raised without an item in progress");

endmodule

// ===== rtl/btmx_dp.sv =====
// btmx_dp: node store, walk registers, allocation counter and result register
// depends on btmx_pkg for payload and command/status structs
`timescale 1ns / 1ps

module btmx_dp import btmx_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int NODE_COUNT = 8192
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in      i_in_data,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_out     o_out_data
);

    localparam int NW       = $clog2(NODE_COUNT);
    localparam int UW       = $clog2(NODE_COUNT + 1);
    localparam int LW       = $clog2(VALUE_BITS);
    localparam int UsedMax  = NODE_COUNT - VALUE_BITS;

    // node store: {link for bit one, link for bit zero}; zero link is null
    logic [2*NW-1:0] mem [NODE_COUNT];

    logic [2*NW-1:0]       r_rdata;
    logic [NW-1:0]         r_node;
    logic                  r_fresh;
    logic [LW-1:0]         r_lvl;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_best;
    logic                  r_query;
    logic [UW-1:0]         r_used;
    logic                  r_holds;
    t_status               r_status;
    t_out                  r_out;

    logic [2*NW-1:0]       links;
    logic [NW-1:0]         link0;
    logic [NW-1:0]         link1;
    logic [NW-1:0]         same;
    logic [NW-1:0]         other;
    logic [NW-1:0]         new_node;
    logic [NW-1:0]         n_node;
    logic [NW-1:0]         rd_addr;
    logic [2*NW-1:0]       wr_data;
    logic [VALUE_BITS-1:0] n_best;
    logic                  bit_v;
    logic                  alloc;
    logic                  take_other;
    logic                  in_full;
    logic                  in_empty;

    // current node links; a freshly allocated node has none
    assign links    = r_fresh ? '0 : r_rdata;
    assign link0    = links[NW-1:0];
    assign link1    = links[2*NW-1:NW];
    assign bit_v    = r_value[VALUE_BITS-1];
    assign same     = bit_v ? link1 : link0;
    assign other    = bit_v ? link0 : link1;
    assign new_node = r_used[NW-1:0];

    // one level of the walk
    assign alloc      = i_cmd.step && !r_query && (same == '0);
    assign take_other = r_query && (other != '0);
    assign wr_data    = bit_v ? {new_node, link0} : {link1, new_node};
    assign n_best     = {r_best[VALUE_BITS-2:0], take_other};

    always_comb begin
        if (r_query) begin
            n_node = take_other ? other : same;
        end else begin
            n_node = alloc ? new_node : same;
        end
    end

    assign rd_addr = i_cmd.start ? '0 : n_node;

    // checks on the item at the input
    assign in_full  = (i_in_data.command == CMD_INSERT) && (r_used > UW'(UsedMax));
    assign in_empty = (i_in_data.command == CMD_QUERY) && !r_holds;

    assign o_stat.special = in_full || in_empty;
    assign o_stat.last    = (r_lvl == '0);

    // node store ports; read only on a transfer or a step so a held level keeps its links
    always_ff @(posedge i_clk) begin
        if (alloc) begin
            mem[r_node] <= wr_data;
        end
        if (i_cmd.start || i_cmd.step) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // allocation count and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= UW'(1);
            r_holds <= 1'b0;
        end else begin
            if (i_cmd.start && (i_in_data.command == CMD_INSERT) && !in_full) begin
                r_holds <= 1'b1;
            end
            if (alloc) begin
                r_used <= r_used + UW'(1);
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_value <= VALUE_BITS'(i_in_data.value);
            r_query <= (i_in_data.command == CMD_QUERY);
            r_lvl   <= LW'(VALUE_BITS - 1);
            r_best  <= '0;
            r_node  <= '0;
            r_fresh <= !r_holds;
            if (in_full) begin
                r_status <= ST_FULL;
            end else if (in_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end else if (i_cmd.step) begin
            r_value <= {r_value[VALUE_BITS-2:0], 1'b0};
            r_lvl   <= r_lvl - LW'(1);
            r_best  <= n_best;
            r_node  <= n_node;
            r_fresh <= alloc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.max_xor <= 32'(i_cmd.step ? n_best : r_best);
            r_out.status  <= r_status;
        end
    end

    assign o_out_data = r_out;

    // allocation never runs past the store
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |-> (r_used < UW'(NODE_COUNT)))
        else $error("node allocation beyond store size");

    // a write never collides with the next read
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |-> (rd_addr != r_node))
        else $error("node store write and read at same address");

    // paths are full depth, so a query never meets a null link above bit zero
    a_query_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_query && !o_stat.last) |-> (n_node != '0))
        else $error("query walk hit a null link");

endmodule

// ===== rtl/binary_trie_max_xor.sv =====
// binary_trie_max_xor: top level of the trie insert / max-xor query block
// depends on btmx_pkg, btmx_ctrl and btmx_dp
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out)
//
// a walking item stalls the input for its whole walk, one node store read per trie level;
// each read gives the address of the next read, so levels do not overlap, and its result
// loads at the last level once the output register is free.
// an empty query or a rejected insert skips the walk and stalls the input until its result loads.
// one item is in work at a time; the next transfer is taken while a result waits.
// a stalled result holds the last walk level until the output register frees up.
// reset empties the trie at once; node contents are valid only once allocated.
`timescale 1ns / 1ps

module binary_trie_max_xor import btmx_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int NODE_COUNT = 8192
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    btmx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // node store and walk
    btmx_dp #(
        .VALUE_BITS (VALUE_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for the binary trie insert / max-xor query block
// depends on btmx_pkg and binary_trie_max_xor; a shadow trie predicts every untyped result
`timescale 1ns / 1ps

module tb_top;
    import btmx_pkg::*;

    localparam int VALUE_BITS     = 32;
    localparam int NODE_COUNT     = 8192;
    localparam int WALK_LATENCY   = VALUE_BITS + 1;
    localparam int DIR_ROWS       = 22;
    localparam int RAND_ITEMS     = 1250;
    localparam int FILL_START     = 700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // receiver stall patterns
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // one row of the directed stimulus
    typedef struct {
        logic        cmd;
        logic [31:0] value;
        bit          typed;
        logic [31:0] xor_val;
        t_status     st;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    // shadow copy of the trie
    int unsigned shadow_links [NODE_COUNT][2];
    int unsigned shadow_used     = 1;
    bit          shadow_nonempty = 1'b0;

    t_out     pending_results [$];
    t_dir_row dir_rows [DIR_ROWS];
    logic [23:0] cluster_pfx [4];

    int mismatches    = 0;
    int checked       = 0;
    int quiet_cycles  = 0;
    int burst_left    = 0;
    int gap_max       = 0;
    int n_insert_ok   = 0;
    int n_insert_full = 0;
    int n_query_ok    = 0;
    int n_query_empty = 0;

    binary_trie_max_xor #(
        .VALUE_BITS (VALUE_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // walk the shadow trie for one item and return its result
    function automatic t_out trie_predict(input t_in item);
        t_out        res;
        int unsigned node;
        int unsigned nxt;
        logic        b;
        int          lvl;
        res  = '0;
        node = 0;
        if (item.command == CMD_INSERT) begin
            if (NODE_COUNT - shadow_used < VALUE_BITS) begin
                res.status = ST_FULL;
            end else begin
                // allocate every missing child on the path
                for (lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
                    b = item.value[lvl];
                    if (shadow_links[node][b] == 0) begin
                        shadow_links[node][b] = shadow_used;
                        shadow_used++;
                    end
                    node = shadow_links[node][b];
                end
                shadow_nonempty = 1'b1;
                res.status = ST_OK;
            end
        end else if (!shadow_nonempty) begin
            res.status = ST_EMPTY;
        end else begin
            // greedy walk preferring the opposite bit
            res.status = ST_OK;
            for (lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
                b = item.value[lvl];
                if (shadow_links[node][b ^ 1'b1] != 0) begin
                    res.max_xor[lvl] = 1'b1;
                    nxt = shadow_links[node][b ^ 1'b1];
                end else begin
                    nxt = shadow_links[node][b];
                end
                if (nxt == 0) break;
                node = nxt;
            end
        end
        return res;
    endfunction

    // present one item in bursts with random gaps, wait for its transfer
    task automatic send_item(input t_in item, input bit typed, input t_out typed_res);
        t_out res;
        int   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = item;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        res = trie_predict(item);
        case (res.status)
            ST_FULL:  n_insert_full++;
            ST_EMPTY: n_query_empty++;
            default: begin
                if (item.command == CMD_INSERT) n_insert_ok++;
                else n_query_ok++;
            end
        endcase
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
    endtask

    // hold the sender off until every expected result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern
    initial begin
        t_stall_mode mode;
        int          span;
        int          tick;
        i_out_stall = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(3, 0));
            span = $urandom_range(300, 50);
            for (tick = 0; tick < span; tick++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_LIGHT:    i_out_stall = ($urandom_range(3, 0) == 0);
                    STALL_HEAVY:    i_out_stall = ($urandom_range(3, 0) != 0);
                    STALL_PERIODIC: i_out_stall = ((tick % 8) < 3);
                    default:        i_out_stall = 1'b0;
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: max_xor %h status %0d",
                             o_out_data.max_xor, o_out_data.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (o_out_data.max_xor !== want.max_xor || o_out_data.status !== want.status) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: expected max_xor %h status %0d, got max_xor %h status %0d",
                                 want.max_xor, want.status,
                                 o_out_data.max_xor, o_out_data.status);
                    mismatches++;
                end
            end
        end
    end

    // count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // main sequence
    initial begin
        t_in  item;
        t_out typed_res;
        bit   wide;
        bit   late;
        int   idx;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // directed rows: empty set, extremes, duplicates, mixed patterns
        dir_rows = '{
            '{CMD_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{CMD_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{CMD_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK},
            '{CMD_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
            '{CMD_QUERY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK},
            '{CMD_QUERY,  32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'h1234_5678, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'h7FFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
            '{CMD_QUERY,  32'hDEAD_BEEF, 1'b0, 32'h0000_0000, ST_OK}
        };

        // hold reset, then release it
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, no sender gaps
        gap_max = 0;
        for (idx = 0; idx < DIR_ROWS; idx++) begin
            item.command      = dir_rows[idx].cmd;
            item.value        = dir_rows[idx].value;
            typed_res.max_xor = dir_rows[idx].xor_val;
            typed_res.status  = dir_rows[idx].st;
            send_item(item, dir_rows[idx].typed, typed_res);
        end
        drain_results();

        // random part: clustered values grow the trie slowly, wide values fill it late
        foreach (cluster_pfx[k]) cluster_pfx[k] = 24'($urandom());
        for (idx = 0; idx < RAND_ITEMS; idx++) begin
            if (idx % 100 == 0) begin
                case ($urandom_range(2, 0))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 12;
                endcase
            end
            if (idx == RAND_ITEMS / 2) drain_results();
            late = (idx >= FILL_START);
            item.command = ($urandom_range(99, 0) < (late ? 70 : 40)) ? CMD_INSERT : CMD_QUERY;
            if (item.command == CMD_INSERT) wide = ($urandom_range(99, 0) < (late ? 85 : 15));
            else wide = 1'($urandom_range(1, 0));
            item.value = wide ? $urandom()
                              : {cluster_pfx[$urandom_range(3, 0)], 8'($urandom())};
            send_item(item, 1'b0, '0);
        end

        // drain and let the walk latency pass for any stray result
        drain_results();
        repeat (4 * WALK_LATENCY) @(posedge i_clk);

        $display("covered %0d results: %0d inserts stored, %0d refused on a full store",
                 checked, n_insert_ok, n_insert_full);
        $display("%0d queries answered, %0d on an empty trie, %0d of %0d nodes in use",
                 n_query_ok, n_query_empty, shadow_used, NODE_COUNT);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
